// ===== rtl/core/fce_pkg.sv =====
// Types and constants shared by the Fenwick count engine files.
package fce_pkg;

    localparam int KIND_W   = 2;
    localparam int POS_W    = 11;
    localparam int CNT_W    = 32;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 11;
    // Walk index: one bit above a position so an upward step past the size still fits
    localparam int IDX_W    = POS_W + 1;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET    = 11'd1024;
    localparam logic [1:0]        REG_SIZE_ADDR = 2'd0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
    } item_t;

    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic [STATUS_W-1:0] status;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/core/fce_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module fce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/fenwick_count_engine_core.sv =====
// Top level of the Fenwick count engine: control sequencer, tree RAM and APB register.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+------------------------
//  item      | in        | item_valid / item_ready       | fce_pkg::item_t
//  result    | out       | result_valid / result_ready   | fce_pkg::result_t
//  apb       | in/out    | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// An add or query walks the tree one node per cycle (at most log2(TREE_SIZE)+1
// nodes visited), set by the single read-modify-write path of the tree RAM.
// A bad position, a dropped add or an unused kind goes straight to the response.
// A clear zeroes every word of the tree RAM; after reset the same zeroing pass
// runs before the first item is taken. APB writes are taken at any time.
// A stalled result holds in the output register while the next transaction is accepted.
module fenwick_count_engine_core #(
    parameter int TREE_SIZE = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  fce_pkg::item_t          item,
    output logic                    result_valid,
    input  logic                    result_ready,
    output fce_pkg::result_t        result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [1:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    import fce_pkg::*;

    localparam int AW = $clog2(TREE_SIZE);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     lim_reg, lim_next;
    logic [CNT_W-1:0]     acc_reg, acc_next;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [KIND_W-1:0]    op_reg, op_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic                 clr_item_reg, clr_item_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [SIZE_W-1:0]    size_reg;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_data_reg, out_data_next;

    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [CNT_W-1:0]     wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [CNT_W-1:0]     rd_data;

    logic [IDX_W-1:0]     lim_calc;
    logic [IDX_W-1:0]     pos_idx;
    logic                 pos_ok;
    logic [IDX_W-1:0]     step;
    logic [IDX_W-1:0]     nxt_up;
    logic [IDX_W-1:0]     nxt_down;

    fce_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TREE_SIZE)
    ) u_tree_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // APB register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == REG_SIZE_ADDR) ? 32'(size_reg) : 32'd0;

    // Effective size: register limited to the tree depth
    always_comb
    begin
        if (32'(size_reg) > 32'(TREE_SIZE))
        begin
            lim_calc = IDX_W'(TREE_SIZE);
        end
        else
        begin
            lim_calc = IDX_W'(size_reg);
        end
    end

    assign pos_idx  = IDX_W'(item.position);
    assign pos_ok   = (pos_idx != '0) && (pos_idx <= lim_calc);
    assign step     = idx_reg & (~idx_reg + IDX_W'(1));
    assign nxt_up   = idx_reg + step;
    assign nxt_down = idx_reg - step;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        acc_next       = acc_reg;
        total_next     = total_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        clr_item_next  = clr_item_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                if (clr_cnt_reg == AW'(TREE_SIZE - 1))
                begin
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? ST_RESP : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (item_valid)
                begin
                    op_next     = item.kind;
                    acc_next    = '0;
                    status_next = STATUS_OK;
                    lim_next    = lim_calc;
                    state_next  = ST_RESP;
                    case (item.kind)
                        KIND_ADD:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else if (total_reg == '1)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                total_next = total_reg + CNT_W'(1);
                                idx_next   = pos_idx;
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pos_idx - IDX_W'(1));
                                state_next = ST_WALK;
                            end
                        end
                        KIND_QUERY:
                        begin
                            if (!pos_ok)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else if (pos_idx != IDX_W'(1))
                            begin
                                // walk down from the position just below
                                idx_next   = pos_idx - IDX_W'(1);
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pos_idx - IDX_W'(2));
                                state_next = ST_WALK;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            total_next    = '0;
                            clr_cnt_next  = '0;
                            clr_item_next = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // rd_data holds the node at idx_reg
                if (op_reg == KIND_ADD)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg - IDX_W'(1));
                    wr_data = rd_data + CNT_W'(1);
                    if (nxt_up <= lim_reg)
                    begin
                        idx_next = nxt_up;
                        rd_en    = 1'b1;
                        rd_addr  = AW'(nxt_up - IDX_W'(1));
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
                else
                begin
                    acc_next = acc_reg + rd_data;
                    if (nxt_down != '0)
                    begin
                        idx_next = nxt_down;
                        rd_en    = 1'b1;
                        rd_addr  = AW'(nxt_down - IDX_W'(1));
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_RESP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.status = status_reg;
                    if ((op_reg == KIND_QUERY) && (status_reg == STATUS_OK)
                        && (acc_reg <= total_reg))
                    begin
                        out_data_next.count = total_reg - acc_reg;
                    end
                    else
                    begin
                        out_data_next.count = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            total_reg     <= '0;
            clr_item_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            clr_item_reg  <= clr_item_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        lim_reg      <= lim_next;
        acc_reg      <= acc_next;
        op_reg       <= op_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== rtl/core/fce_checker.sv =====
// Port-level assertions for the Fenwick count engine and their bind.
module fce_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_ready,
    input fce_pkg::item_t    item,
    input logic              result_valid,
    input logic              result_ready,
    input fce_pkg::result_t  result
);

    import fce_pkg::*;

    // A stalled result transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // Each item is worked on alone: no accept in the cycle after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while previous one still in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.status == STATUS_OK) || (result.status == STATUS_RANGE)
            || (result.status == STATUS_FULL))
        else $error("undefined status code");

    // Flagged results carry no count
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status != STATUS_OK) |-> result.count == '0)
        else $error("flagged result with nonzero count");

    // A clear keeps the input closed for the sweep
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item.kind == KIND_CLEAR) |=> ##1 !item_ready)
        else $error("input opened during clear sweep");

endmodule

bind fenwick_count_engine_core fce_checker u_fce_checker (.*);
